// ----- rtl/merge_sort_ascending_int_assert.svh -----
// Assertion macros shared by the merge sort block.
`ifndef MERGE_SORT_ASCENDING_INT_ASSERT_SVH
`define MERGE_SORT_ASCENDING_INT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MSORT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MSORT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/msort_pkg.sv -----
// Package with the constants, types and state codes of the merge sort block.
package msort_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_W     = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int RANGE_W     = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LAST  = 1'b1;

	// One classified input beat on its way from the front to the back.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [ADDR_W-1:0]  addr;
		logic               drop;
		logic               last;
		logic [CNT_W-1:0]   count;
		logic               ovf;
	} msort_entry_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range_first;
		logic [RANGE_W-1:0] range_last;
	} msort_cfg_t;

	typedef struct packed {
		logic               strobe;
		logic [VALUE_W-1:0] value;
		logic               final_res;
		logic               truncated;
	} msort_result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_MINIT,
		B_MERGE,
		B_EMIT
	} back_state_t;

endpackage

// ----- rtl/merge_sort_ascending_int.sv -----
// Top level of the ascending merge sort block over signed 32-bit values.
//
//   Channel   Signals                                   Handshake
//   input     start, busy, value, last                  beat taken when start && !busy
//   result    done, sorted_value, final_res, truncated  done high with each result beat
//   config    cfg_we, cfg_index, cfg_data               write when cfg_we is high
//
// Loading accepts one beat per cycle while the four-entry queue has room.
// After the beat marked last, the engine passes through a set-up state, then for each of
// ceil(log2(span)) passes merges one span element per cycle, after an init state per merge,
// and then emits the result run at one loaded element per cycle.
// Reset clears the control state only; the two stores keep no reset value.
// The receiver cannot stall; busy rises only when the queue in front of the engine is full.
module merge_sort_ascending_int (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [msort_pkg::VALUE_W-1:0] value,
	input  logic                            last,
	output logic                            done,
	output logic signed [msort_pkg::VALUE_W-1:0] sorted_value,
	output logic                            final_res,
	output logic                            truncated,
	input  logic                            cfg_we,
	input  logic [msort_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msort_pkg::RANGE_W-1:0]   cfg_data
);

`include "merge_sort_ascending_int_assert.svh"

	msort_pkg::msort_cfg_t    cfg_q;
	msort_pkg::msort_entry_t  entry;
	msort_pkg::msort_entry_t  head;
	msort_pkg::msort_result_t res;
	logic                     push;
	logic                     pop;
	logic                     q_full;
	logic                     q_valid;

	// The range registers must only be written while the block is idle; the block does not
	// enforce this itself, so that the engine may read them directly when a sort begins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_first <= '0;
			cfg_q.range_last  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				msort_pkg::REG_RANGE_FIRST: cfg_q.range_first <= cfg_data;
				msort_pkg::REG_RANGE_LAST:  cfg_q.range_last  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end gives every beat its store position and notes overflow,
	// so that the engine never has to look back at the input side.
	msort_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.last   (last),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.entry  (entry)
	);

	msort_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (entry),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.full      (q_full)
	);

	// The engine ping-pongs between its two stores, one pass per merge width.
	msort_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.res     (res)
	);

	assign done         = res.strobe;
	assign sorted_value = res.value;
	assign final_res    = res.final_res;
	assign truncated    = res.truncated;

	// A result run is emitted without gaps until its final beat.
	`MSORT_ASSERT_NEXT(a_run_contiguous, done && !final_res, done, "result run broken")
	// The overflow flag is the same on every beat of one run.
	`MSORT_ASSERT_NEXT(a_trunc_steady, done && !final_res, $stable(truncated),
		"truncated changed within a run")
	// Flags appear only with a result beat.
	`MSORT_ASSERT_NOW(a_final_strobed, final_res || truncated, done, "flag without strobe")

endmodule

// ----- rtl/msort_front.sv -----
// Front end: accepts input beats, assigns store positions and flags overflow.
module msort_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [msort_pkg::VALUE_W-1:0] value,
	input  logic                          last,
	input  logic                          q_full,
	output logic                          busy,
	output logic                          push,
	output msort_pkg::msort_entry_t       entry
);

	logic [msort_pkg::CNT_W-1:0] cnt_q;
	logic                        ovf_q;
	logic                        drop;

	assign busy = q_full;
	assign push = start && !q_full;
	assign drop = (cnt_q == msort_pkg::CNT_W'(msort_pkg::DEPTH));

	always_comb begin
		entry.value = value;
		entry.addr  = cnt_q[msort_pkg::ADDR_W-1:0];
		entry.drop  = drop;
		entry.last  = last;
		entry.count = drop ? cnt_q : cnt_q + msort_pkg::CNT_W'(1);
		entry.ovf   = ovf_q | drop;
	end

	// A beat marked last closes the load, so the next one starts at position zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (push) begin
			if (last) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= entry.count;
				ovf_q <= entry.ovf;
			end
		end
	end

endmodule

// ----- rtl/msort_queue.sv -----
// Short queue of classified beats between the front end and the sort engine.
module msort_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  msort_pkg::msort_entry_t entry_in,
	input  logic                    pop,
	output msort_pkg::msort_entry_t head,
	output logic                    not_empty,
	output logic                    full
);

	msort_pkg::msort_entry_t            slots_q [msort_pkg::QUEUE_DEPTH];
	logic [msort_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [msort_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [msort_pkg::QCNT_W-1:0]       cnt_q;
	logic                               do_pop;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == msort_pkg::QCNT_W'(msort_pkg::QUEUE_DEPTH));
	assign head      = slots_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + msort_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + msort_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + msort_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - msort_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/msort_back.sv -----
// Back end: stores values, runs the bottom-up merge passes and emits the result.
module msort_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  msort_pkg::msort_cfg_t   cfg,
	input  logic                    q_valid,
	input  msort_pkg::msort_entry_t head,
	output logic                    pop,
	output msort_pkg::msort_result_t res
);

	localparam int AW = msort_pkg::ADDR_W;
	localparam int CW = msort_pkg::CNT_W;
	localparam int VW = msort_pkg::VALUE_W;

	logic [VW-1:0] mem0 [msort_pkg::DEPTH];
	logic [VW-1:0] mem1 [msort_pkg::DEPTH];

	msort_pkg::back_state_t state_q, state_d;

	logic [CW-1:0] i_q, j_q, k_q, start_q, mid_q, end_q, width_q;
	logic [CW-1:0] i_d, j_d, k_d, start_d, mid_d, end_d, width_d;
	logic [CW-1:0] lo_q, hi_q, lo_d, hi_d, n_q, n_d;
	logic          ovf_q, ovf_d, parity_q, parity_d;

	logic [VW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic [VW-1:0] da, db, wr_val;
	logic          take_left, merge_done, in_range;
	logic [CW-1:0] n_minus1, next_start, mid_raw, end_raw, width2;

	logic          mem0_we, mem1_we;
	logic [AW-1:0] mem0_wa;
	logic [VW-1:0] mem0_wd;

	// Source of the current pass is mem1 when parity is set, mem0 otherwise.
	assign da = parity_q ? rd1a_q : rd0a_q;
	assign db = parity_q ? rd1b_q : rd0b_q;

	assign take_left  = (i_q <= mid_q) && ((j_q > end_q) || ($signed(da) <= $signed(db)));
	assign wr_val     = take_left ? da : db;
	assign merge_done = (k_q == end_q);
	assign n_minus1   = n_q - CW'(1);
	assign next_start = start_q + (width_q << 1);
	assign width2     = width_q << 1;
	assign mid_raw    = start_q + width_q - CW'(1);
	assign end_raw    = start_q + (width_q << 1) - CW'(1);
	assign in_range   = (i_q >= lo_q) && (i_q <= hi_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			msort_pkg::B_IDLE: begin
				if (q_valid && head.last) begin
					state_d = msort_pkg::B_SETUP;
				end
			end
			msort_pkg::B_SETUP: begin
				if (lo_d < hi_d) begin
					state_d = msort_pkg::B_MINIT;
				end else begin
					state_d = msort_pkg::B_EMIT;
				end
			end
			msort_pkg::B_MINIT: begin
				state_d = msort_pkg::B_MERGE;
			end
			msort_pkg::B_MERGE: begin
				if (merge_done) begin
					if (next_start <= hi_q) begin
						state_d = msort_pkg::B_MINIT;
					end else if (width2 <= hi_q - lo_q) begin
						state_d = msort_pkg::B_MINIT;
					end else begin
						state_d = msort_pkg::B_EMIT;
					end
				end
			end
			msort_pkg::B_EMIT: begin
				if (i_q == n_minus1) begin
					state_d = msort_pkg::B_IDLE;
				end
			end
			default: state_d = msort_pkg::B_IDLE;
		endcase
	end

	// Datapath next values.
	always_comb begin
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		start_d  = start_q;
		mid_d    = mid_q;
		end_d    = end_q;
		width_d  = width_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		n_d      = n_q;
		ovf_d    = ovf_q;
		parity_d = parity_q;
		case (state_q)
			msort_pkg::B_IDLE: begin
				if (q_valid && head.last) begin
					n_d   = head.count;
					ovf_d = head.ovf;
				end
			end
			msort_pkg::B_SETUP: begin
				lo_d     = CW'(cfg.range_first);
				hi_d     = (CW'(cfg.range_last) > n_minus1) ? n_minus1 : CW'(cfg.range_last);
				width_d  = CW'(1);
				start_d  = CW'(cfg.range_first);
				parity_d = 1'b0;
				i_d      = '0;
			end
			msort_pkg::B_MINIT: begin
				// A tail chunk of a pass with no right run is simply copied.
				mid_d = (mid_raw > hi_q) ? hi_q : mid_raw;
				end_d = (end_raw > hi_q) ? hi_q : end_raw;
				i_d   = start_q;
				j_d   = start_q + width_q;
				k_d   = start_q;
			end
			msort_pkg::B_MERGE: begin
				k_d = k_q + CW'(1);
				if (take_left) begin
					i_d = i_q + CW'(1);
				end else begin
					j_d = j_q + CW'(1);
				end
				if (merge_done) begin
					if (next_start <= hi_q) begin
						start_d = next_start;
					end else begin
						parity_d = !parity_q;
						start_d  = lo_q;
						width_d  = width2;
						i_d      = '0;
					end
				end
			end
			msort_pkg::B_EMIT: begin
				i_d = i_q + CW'(1);
			end
			default: ;
		endcase
	end

	// Outputs.
	always_comb begin
		pop           = (state_q == msort_pkg::B_IDLE) && q_valid;
		res.strobe    = (state_q == msort_pkg::B_EMIT);
		res.value     = (in_range && parity_q) ? rd1a_q : rd0a_q;
		res.final_res = res.strobe && (i_q == n_minus1);
		res.truncated = res.strobe && ovf_q;
		mem0_we       = ((state_q == msort_pkg::B_IDLE) && q_valid && !head.drop) ||
		                ((state_q == msort_pkg::B_MERGE) && parity_q);
		mem1_we       = (state_q == msort_pkg::B_MERGE) && !parity_q;
		mem0_wa       = (state_q == msort_pkg::B_IDLE) ? head.addr : k_q[AW-1:0];
		mem0_wd       = (state_q == msort_pkg::B_IDLE) ? head.value : wr_val;
	end

	always_ff @(posedge clk) begin
		if (mem0_we) begin
			mem0[mem0_wa] <= mem0_wd;
		end
		if (mem1_we) begin
			mem1[k_q[AW-1:0]] <= wr_val;
		end
		rd0a_q <= mem0[i_d[AW-1:0]];
		rd0b_q <= mem0[j_d[AW-1:0]];
		rd1a_q <= mem1[i_d[AW-1:0]];
		rd1b_q <= mem1[j_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		i_q      <= i_d;
		j_q      <= j_d;
		k_q      <= k_d;
		start_q  <= start_d;
		mid_q    <= mid_d;
		end_q    <= end_d;
		width_q  <= width_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		n_q      <= n_d;
		ovf_q    <= ovf_d;
		parity_q <= parity_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msort_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- tb/tb_merge_sort_ascending_int.sv -----
// Self-checking testbench for the ascending merge sort block, with its own sort predictor.
`timescale 1ns / 100ps

module tb_merge_sort_ascending_int;

	// Quiet cycles after the last awaited beat before the range is rewritten,
	// and at the very end to catch any stray result beats.
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 200;
	localparam int MAX_REPORTS   = 20;

	localparam logic signed [msort_pkg::VALUE_W-1:0] VAL_MIN =
		{1'b1, {(msort_pkg::VALUE_W-1){1'b0}}};
	localparam logic signed [msort_pkg::VALUE_W-1:0] VAL_MAX =
		{1'b0, {(msort_pkg::VALUE_W-1){1'b1}}};

	// One result beat as the block should present it.
	typedef struct {
		logic signed [msort_pkg::VALUE_W-1:0] val;
		logic                                 fin;
		logic                                 trunc;
	} sorted_beat_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic signed [msort_pkg::VALUE_W-1:0] value;
	logic                                 last;
	logic                                 done;
	logic signed [msort_pkg::VALUE_W-1:0] sorted_value;
	logic                                 final_res;
	logic                                 truncated;
	logic                                 cfg_we;
	logic [msort_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [msort_pkg::RANGE_W-1:0]        cfg_data;

	// The predictor's own view of the block: the values held in the current load,
	// how many there are, whether any were dropped, and the sort range.
	logic signed [msort_pkg::VALUE_W-1:0] held_vals [msort_pkg::DEPTH];
	int unsigned                          held_count;
	logic                                 held_ovf;
	logic [msort_pkg::RANGE_W-1:0]        span_first;
	logic [msort_pkg::RANGE_W-1:0]        span_last;

	// Result beats still owed by the block, oldest first.
	sorted_beat_t                         awaited_beats [$];
	// Values of the next load to be sent.
	logic signed [msort_pkg::VALUE_W-1:0] load_list [$];

	int unsigned beats_sent;
	int unsigned loads_closed;
	int unsigned beats_checked;
	int unsigned truncated_loads;
	int unsigned mismatch_count;
	// When set, beats of a load go back to back with no idle cycles between them.
	bit          steady;

	merge_sort_ascending_int dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last         (last),
		.done         (done),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.truncated    (truncated),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: even the slowest legal run finishes far inside this time.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	// Every result beat is taken at the edge that ends its cycle; the block cannot
	// be held off, so each one is compared with the oldest awaited beat there and then.
	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (awaited_beats.size() == 0) begin
				flag_mismatch($sformatf("result beat %0d with nothing awaited", sorted_value));
			end else begin
				want = awaited_beats.pop_front();
				beats_checked++;
				if (sorted_value !== want.val)
					flag_mismatch($sformatf("sorted_value %0d, expected %0d",
						sorted_value, want.val));
				if (final_res !== want.fin)
					flag_mismatch($sformatf("final_res %b, expected %b", final_res, want.fin));
				if (truncated !== want.trunc)
					flag_mismatch($sformatf("truncated %b, expected %b", truncated, want.trunc));
			end
		end else if (arst_n === 1'b1 && done !== 1'b0) begin
			flag_mismatch("done is unknown");
		end
	end

	// Folds one accepted beat into the predicted load. A beat marked last closes the
	// load: the span is clamped to the data, sorted ascending, and one result beat per
	// held value is queued. A stable insertion sort gives the same order as the
	// block's stable merge sort, since equal values cannot be told apart.
	function automatic void note_beat(input logic signed [msort_pkg::VALUE_W-1:0] v,
		input logic is_last);
		int unsigned                          top;
		int unsigned                          i;
		int unsigned                          j;
		logic signed [msort_pkg::VALUE_W-1:0] key;
		sorted_beat_t                         beat;
		if (held_count < msort_pkg::DEPTH) begin
			held_vals[held_count] = v;
			held_count++;
		end else begin
			// A full store drops the beat, even one marked last.
			held_ovf = 1'b1;
		end
		if (!is_last)
			return;
		top = (span_last > held_count - 1) ? held_count - 1 : span_last;
		// An empty or inverted span leaves the load as it came in.
		if (span_first < top) begin
			for (i = span_first + 1; i <= top; i++) begin
				key = held_vals[i];
				j = i;
				while (j > span_first && held_vals[j-1] > key) begin
					held_vals[j] = held_vals[j-1];
					j--;
				end
				held_vals[j] = key;
			end
		end
		for (i = 0; i < held_count; i++) begin
			beat.val   = held_vals[i];
			beat.fin   = (i == held_count - 1);
			beat.trunc = held_ovf;
			awaited_beats.push_back(beat);
		end
		loads_closed++;
		if (held_ovf)
			truncated_loads++;
		held_count = 0;
		held_ovf   = 1'b0;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Extremes, small values close to zero (so that ties are common) and full-width noise.
	function automatic logic signed [msort_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2, 3: return $signed($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Range ends favour the corners and small positions, where loads actually reach.
	function automatic logic [msort_pkg::RANGE_W-1:0] pick_span_end();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return msort_pkg::RANGE_W'($urandom_range(0, 63));
			default: return msort_pkg::RANGE_W'($urandom_range(0, 10));
		endcase
	endfunction

	// Offers one beat and holds it until the block takes it. Start is only lowered
	// when a gap follows, so a run of beats keeps it high without a glitch.
	task automatic send_beat(input logic signed [msort_pkg::VALUE_W-1:0] v,
		input logic is_last);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last  <= is_last;
		do @(posedge clk); while (busy !== 1'b0);
		beats_sent++;
		note_beat(v, is_last);
	endtask

	// Sends the values in load_list as one load, the final beat marked last.
	task automatic send_load();
		int unsigned i;
		for (i = 0; i < load_list.size(); i++)
			send_beat(load_list[i], i == load_list.size() - 1);
	endtask

	task automatic send_random_load(input int unsigned n);
		int unsigned i;
		load_list.delete();
		for (i = 0; i < n; i++)
			load_list.push_back(pick_value());
		send_load();
	endtask

	// Waits until every awaited beat has come back, then lets the block go quiet.
	task automatic settle();
		start <= 1'b0;
		while (awaited_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Rewrites both range registers while the block is idle.
	task automatic set_sort_span(input logic [msort_pkg::RANGE_W-1:0] first,
		input logic [msort_pkg::RANGE_W-1:0] final_pos);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= msort_pkg::REG_RANGE_FIRST;
		cfg_data  <= first;
		@(posedge clk);
		cfg_index <= msort_pkg::REG_RANGE_LAST;
		cfg_data  <= final_pos;
		@(posedge clk);
		cfg_we    <= 1'b0;
		span_first = first;
		span_last  = final_pos;
	endtask

	// The range is left at its reset value, the whole store, which gets clamped to
	// each load: a single beat, a pair of extremes, and a mix with duplicates.
	task automatic test_reset_defaults();
		load_list = '{VAL_MIN};
		send_load();
		load_list = '{VAL_MAX, VAL_MIN};
		send_load();
		load_list = '{5, -1, 5, VAL_MIN, VAL_MAX, 0};
		send_load();
	endtask

	// Range corners: an inverted range, a range of one position, a range with values
	// outside it on both sides, and a range that starts past the end of the data.
	task automatic test_range_corners();
		set_sort_span('1, '0);
		load_list = '{3, 2, 1};
		send_load();
		set_sort_span(6'd2, 6'd2);
		load_list = '{9, 8, 7, 6};
		send_load();
		set_sort_span(6'd1, 6'd4);
		load_list = '{40, 30, -20, 10, 0, -50};
		send_load();
		set_sort_span(6'd5, '1);
		load_list = '{2, 1, 0};
		send_load();
	endtask

	// Several range settings, each with a couple of loads of random content. Most
	// loads are short; now and then one fills a good part of the store.
	task automatic test_random_loads();
		int unsigned phase;
		int unsigned ld;
		int unsigned n;
		for (phase = 0; phase < 4; phase++) begin
			set_sort_span(pick_span_end(), pick_span_end());
			for (ld = 0; ld < 2; ld++) begin
				steady = ($urandom_range(0, 3) == 0);
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(16, msort_pkg::DEPTH)
					: $urandom_range(1, 8);
				send_random_load(n);
			end
		end
		steady = 1'b0;
	endtask

	// Fills the store over the top so that two beats, the last one among them, are
	// dropped, then checks that the next load is no longer flagged as truncated.
	task automatic test_store_overflow();
		set_sort_span('0, '1);
		send_random_load(msort_pkg::DEPTH + 2);
		send_random_load(3);
	endtask

	initial begin
		start     <= 1'b0;
		value     <= '0;
		last      <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= msort_pkg::REG_RANGE_FIRST;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		// Predictor state as the block holds it straight after reset.
		held_count      = 0;
		held_ovf        = 1'b0;
		span_first      = '0;
		span_last       = '1;
		steady          = 1'b0;
		beats_sent      = 0;
		loads_closed    = 0;
		beats_checked   = 0;
		truncated_loads = 0;
		mismatch_count  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_range_corners();
		test_random_loads();
		test_store_overflow();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_beats.size() != 0)
			flag_mismatch($sformatf("%0d result beats never arrived", awaited_beats.size()));

		$display("Sent %0d beats in %0d loads over a range of sort spans, corners included.",
			beats_sent, loads_closed);
		$display("Checked %0d result beats; %0d loads overflowed the store.",
			beats_checked, truncated_loads);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
